>>> hw/rtl/sfet_pkg.sv
// Shared types and constants for the sorted frame event table.
package sfet_pkg;

    localparam int TABLE_DEPTH = 512;
    localparam int FRAME_W     = 31;
    localparam int MASK_W      = 32;
    localparam int OP_W        = 2;
    localparam int COUNT_OUT_W = 10;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int WALK_W      = $clog2(TABLE_DEPTH);

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [FRAME_W-1:0] frame_number;
        logic [MASK_W-1:0]  button_mask;
    } in_word_t;

    typedef struct packed {
        logic [MASK_W-1:0]      found_mask;
        logic [COUNT_OUT_W-1:0] stored_count;
        logic                   table_active;
        logic                   insert_accepted;
    } out_word_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [MASK_W-1:0]  mask;
    } entry_t;

    // Broadcast to every cell of the row.
    typedef struct packed {
        logic   ins_en;
        logic   walk_en;
        entry_t key;
    } cell_ctrl_t;

endpackage

>>> hw/rtl/sfet_cell.sv
// One table slot: holds an entry, shifts it right on insert, relays query matches.
module sfet_cell (
    input  logic                        aclk,
    input  sfet_pkg::cell_ctrl_t        ctrl,
    input  logic                        occupied,
    input  logic                        left_open,
    input  sfet_pkg::entry_t            left_entry,
    input  logic [sfet_pkg::MASK_W-1:0] left_carry,
    output logic                        open,
    output sfet_pkg::entry_t            entry,
    output logic [sfet_pkg::MASK_W-1:0] carry
);
    import sfet_pkg::*;

    entry_t            entry_reg;
    entry_t            entry_next;
    logic [MASK_W-1:0] carry_reg;
    logic [MASK_W-1:0] carry_next;
    logic              above;

    // Slot is open to the key when empty or holding a later frame.
    assign above = entry_reg.frame > ctrl.key.frame;
    assign open  = !occupied || above;

    always_comb begin
        entry_next = entry_reg;
        if (left_open) begin
            entry_next = left_entry;
        end else if (open) begin
            entry_next = ctrl.key;
        end
    end

    // Take own mask if at or below the key, else pass the left one along.
    assign carry_next = (occupied && !above) ? entry_reg.mask : left_carry;

    always_ff @(posedge aclk) begin
        if (ctrl.ins_en) begin
            entry_reg <= entry_next;
        end
        if (ctrl.walk_en) begin
            carry_reg <= carry_next;
        end
    end

    assign entry = entry_reg;
    assign carry = carry_reg;

endmodule

>>> hw/rtl/sorted_frame_event_table.sv
// Top level of the sorted frame event table: control sequencer and row of cells.
//
// Usage: each word on the s_ channel (s_valid/s_ready/s_data) is one operation:
// clear, insert (frame, mask) or query (frame). Every word yields exactly one
// result word on the m_ channel (m_valid/m_ready/m_data) with the query mask,
// the entry count after the operation, a non-empty flag and an insert flag.
// Entries live in a row of TABLE_DEPTH cells kept in ascending frame order.
// An insert shifts every later entry one cell right, all at once; a
// full table drops the insert. A query walks a match token down the row, one
// cell per cycle, so the last cell ends up with the mask of the last entry at
// or below the query frame.
// A new word is taken only while the sequencer is idle: each word is executed,
// a query then walks the whole cell row, and the result is registered for the
// m_ channel before the next word is accepted.
// Reset (aresetn low, synchronous) empties the table and drops any pending
// result. When the receiver stalls, the finished result is held in the output
// register and a new word is still taken; that word's result waits until the
// output register frees up.
module sorted_frame_event_table (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sfet_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sfet_pkg::out_word_t m_data
);
    import sfet_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_DONE
    } state_t;

    state_t             state_reg;
    in_word_t           word_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [WALK_W-1:0]  walk_reg;
    logic               accepted_reg;
    logic               m_valid_reg;
    out_word_t          m_data_reg;

    logic               full;
    cell_ctrl_t         ctrl;
    logic [TABLE_DEPTH-1:0] occ;
    logic [TABLE_DEPTH-1:0] open_v;
    entry_t             entry_v [TABLE_DEPTH];
    logic [MASK_W-1:0]  carry_v [TABLE_DEPTH];
    out_word_t          result;

    assign full    = count_reg == CNT_W'(TABLE_DEPTH);
    assign s_ready = state_reg == ST_IDLE;

    // Broadcast the held word to every cell.
    assign ctrl.key     = '{frame: word_reg.frame_number, mask: word_reg.button_mask};
    assign ctrl.ins_en  = (state_reg == ST_EXEC) && (word_reg.operation == OP_INSERT)
                          && !full;
    assign ctrl.walk_en = state_reg == ST_WALK;

    // Row of cells: cell 0 has no left neighbor, so it never shifts in.
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        assign occ[i] = CNT_W'(i) < count_reg;
        if (i == 0) begin : g_first
            sfet_cell u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .occupied   (occ[i]),
                .left_open  (1'b0),
                .left_entry (ctrl.key),
                .left_carry ({MASK_W{1'b0}}),
                .open       (open_v[i]),
                .entry      (entry_v[i]),
                .carry      (carry_v[i])
            );
        end else begin : g_rest
            sfet_cell u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .occupied   (occ[i]),
                .left_open  (open_v[i-1]),
                .left_entry (entry_v[i-1]),
                .left_carry (carry_v[i-1]),
                .open       (open_v[i]),
                .entry      (entry_v[i]),
                .carry      (carry_v[i])
            );
        end
    end

    // Result word assembled from the settled count and the end of the row.
    always_comb begin
        result.found_mask      = (word_reg.operation == OP_QUERY)
                                 ? carry_v[TABLE_DEPTH-1] : {MASK_W{1'b0}};
        result.stored_count    = COUNT_OUT_W'(count_reg);
        result.table_active    = count_reg != '0;
        result.insert_accepted = accepted_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            walk_reg     <= '0;
            accepted_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            // Drop the output word once the receiver takes it; in ST_DONE the
            // next result takes its place instead.
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        word_reg  <= s_data;
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    accepted_reg <= 1'b0;
                    walk_reg     <= '0;
                    state_reg    <= ST_DONE;
                    case (word_reg.operation)
                        OP_CLEAR: begin
                            count_reg <= '0;
                        end
                        OP_INSERT: begin
                            if (!full) begin
                                count_reg    <= count_reg + CNT_W'(1);
                                accepted_reg <= 1'b1;
                            end
                        end
                        OP_QUERY: begin
                            state_reg <= ST_WALK;
                        end
                        default: begin
                            // Unused code: hold the table.
                        end
                    endcase
                end
                ST_WALK: begin
                    // Advance the match token one cell per cycle.
                    walk_reg <= walk_reg + WALK_W'(1);
                    if (walk_reg == WALK_W'(TABLE_DEPTH - 1)) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // Hold here while the previous result is still waiting.
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= result;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sorted frame event table: directed and random operations.
module tb;
    import sfet_pkg::*;

    // Operation code that the block must pass through as a no-op.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic [FRAME_W-1:0] FRAME_MAX  = {FRAME_W{1'b1}};
    localparam logic [MASK_W-1:0]  MASK_ONES  = {MASK_W{1'b1}};
    // Narrow frame range so that equal frames and exact query hits are common.
    localparam int unsigned FRAME_SPAN        = 256;
    localparam int unsigned RANDOM_PHASE_LEN  = 205;
    // A query walks the whole row; allow many of those back to back with no handshake.
    localparam int unsigned WATCHDOG_LIMIT    = 10 * (TABLE_DEPTH + 3);

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    // Words waiting to be driven and results waiting to be seen.
    in_word_t  pending_words[$];
    out_word_t expected_results[$];

    // Shadow copy of the table contents.
    logic [FRAME_W-1:0] shadow_frames[TABLE_DEPTH];
    logic [MASK_W-1:0]  shadow_masks[TABLE_DEPTH];
    int unsigned        shadow_count = 0;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;

    sorted_frame_event_table u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // Count of stored entries whose frame is at or below the given frame.
    function automatic int unsigned entries_at_or_below(input logic [FRAME_W-1:0] frame);
        int unsigned n;
        n = 0;
        while (n < shadow_count && shadow_frames[n] <= frame)
            n++;
        return n;
    endfunction

    // Apply one word to the shadow table and return the result it must produce.
    function automatic out_word_t apply_operation(input in_word_t word);
        out_word_t   res;
        int unsigned pos;
        int unsigned idx;
        res = '0;
        case (word.operation)
            OP_CLEAR: begin
                shadow_count = 0;
            end
            OP_INSERT: begin
                // Drop the insert when the table is full.
                if (shadow_count < TABLE_DEPTH) begin
                    // Land after every equal frame so equal frames keep arrival order.
                    pos = entries_at_or_below(word.frame_number);
                    for (idx = shadow_count; idx > pos; idx--) begin
                        shadow_frames[idx] = shadow_frames[idx - 1];
                        shadow_masks[idx]  = shadow_masks[idx - 1];
                    end
                    shadow_frames[pos] = word.frame_number;
                    shadow_masks[pos]  = word.button_mask;
                    shadow_count++;
                    res.insert_accepted = 1'b1;
                end
            end
            OP_QUERY: begin
                pos = entries_at_or_below(word.frame_number);
                if (pos > 0)
                    res.found_mask = shadow_masks[pos - 1];
            end
            default: begin
            end
        endcase
        res.stored_count = COUNT_OUT_W'(shadow_count);
        res.table_active = (shadow_count != 0);
        return res;
    endfunction

    // Mostly small frames, some across the full range, some at the edges.
    function automatic logic [FRAME_W-1:0] pick_frame();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return FRAME_W'($urandom_range(FRAME_SPAN - 1));
        else if (roll < 85)
            return FRAME_W'($urandom);
        else if (roll < 90)
            return '0;
        else if (roll < 95)
            return FRAME_MAX;
        else
            return FRAME_MAX - 1'b1;
    endfunction

    function automatic logic [MASK_W-1:0] pick_mask();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 5)
            return '0;
        else if (roll < 10)
            return MASK_ONES;
        else
            return MASK_W'($urandom);
    endfunction

    task automatic push_word(input logic [OP_W-1:0] op, input logic [FRAME_W-1:0] frame,
                             input logic [MASK_W-1:0] mask);
        in_word_t word;
        word.operation    = op;
        word.frame_number = frame;
        word.button_mask  = mask;
        pending_words.push_back(word);
    endtask

    // Inserts and queries dominate so the table grows between the rare clears.
    task automatic push_random_word();
        int unsigned      roll;
        logic [OP_W-1:0]  op;
        roll = $urandom_range(99);
        if (roll < 50)
            op = OP_INSERT;
        else if (roll < 95)
            op = OP_QUERY;
        else if (roll < 97)
            op = OP_CLEAR;
        else
            op = OP_UNUSED;
        push_word(op, pick_frame(), pick_mask());
    endtask

    // Hold until every queued word is accepted and every result has come back.
    task automatic wait_for_drain();
        while (pending_words.size() != 0 || s_valid || expected_results.size() != 0)
            @(negedge aclk);
    endtask

    // Driver: hold the word until accepted, then advance to the next one or idle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
        end else begin
            if (s_valid && s_ready)
                expected_results.push_back(apply_operation(s_data));
            if (!s_valid || s_ready) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_words.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted result word against the oldest expectation.
    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result word with nothing expected: %h", m_data);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.found_mask !== want.found_mask) begin
                        $error("found_mask: expected %h, got %h",
                               want.found_mask, m_data.found_mask);
                        mismatch_count++;
                    end
                    if (m_data.stored_count !== want.stored_count) begin
                        $error("stored_count: expected %0d, got %0d",
                               want.stored_count, m_data.stored_count);
                        mismatch_count++;
                    end
                    if (m_data.table_active !== want.table_active) begin
                        $error("table_active: expected %b, got %b",
                               want.table_active, m_data.table_active);
                        mismatch_count++;
                    end
                    if (m_data.insert_accepted !== want.insert_accepted) begin
                        $error("insert_accepted: expected %b, got %b",
                               want.insert_accepted, m_data.insert_accepted);
                        mismatch_count++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: end the run if no word moves on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int unsigned phase;
        int unsigned n;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty table, equal frames, edges of frame and mask, unused code.
        push_word(OP_QUERY, '0, MASK_ONES);
        push_word(OP_UNUSED, FRAME_MAX, MASK_ONES);
        push_word(OP_INSERT, FRAME_W'(100), 32'hA5A5_0001);
        push_word(OP_INSERT, FRAME_W'(100), 32'h5A5A_0002);
        push_word(OP_INSERT, FRAME_W'(50), 32'h0000_0C0C);
        push_word(OP_QUERY, FRAME_W'(49), '0);
        push_word(OP_QUERY, FRAME_W'(50), '0);
        push_word(OP_QUERY, FRAME_W'(100), '0);
        push_word(OP_QUERY, FRAME_MAX, '0);
        push_word(OP_INSERT, FRAME_MAX, '0);
        push_word(OP_INSERT, '0, MASK_ONES);
        push_word(OP_QUERY, FRAME_MAX, MASK_ONES);
        push_word(OP_QUERY, '0, '0);
        push_word(OP_CLEAR, FRAME_MAX, MASK_ONES);
        push_word(OP_QUERY, FRAME_MAX, '0);
        push_word(OP_INSERT, FRAME_MAX, MASK_ONES);
        push_word(OP_QUERY, FRAME_MAX - 1'b1, '0);
        push_word(OP_QUERY, FRAME_MAX, '0);
        push_word(OP_UNUSED, '0, '0);
        push_word(OP_CLEAR, '0, '0);
        // Pause the sender until every result is back.
        wait_for_drain();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            if (phase == 0) begin
                // Fill the table to the brim, then push inserts that must drop.
                push_word(OP_CLEAR, '0, '0);
                for (n = 0; n < TABLE_DEPTH; n++)
                    push_word(OP_INSERT, pick_frame(), pick_mask());
                push_word(OP_INSERT, FRAME_MAX, MASK_ONES);
                push_word(OP_INSERT, '0, '0);
                for (n = 0; n < 4; n++)
                    push_word(OP_INSERT, pick_frame(), pick_mask());
                push_word(OP_QUERY, '0, '0);
                push_word(OP_QUERY, FRAME_MAX, '0);
                for (n = 0; n < 14; n++)
                    push_word(OP_QUERY, pick_frame(), pick_mask());
                push_word(OP_UNUSED, pick_frame(), pick_mask());
            end else begin
                for (n = 0; n < RANDOM_PHASE_LEN; n++)
                    push_random_word();
            end
            wait_for_drain();
        end

        // Leave room for any stray result word after the last query latency.
        repeat (TABLE_DEPTH + 10) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/sfet_pkg.sv
hw/rtl/sfet_cell.sv
hw/rtl/sorted_frame_event_table.sv
tb/tb.sv
